### sv/lil_pkg.sv
// ============================================================================
// lil_pkg: shared types and constants for the linear interpolation table
// Item layouts of both channels and the configuration register indexes.
// ============================================================================
`default_nettype none

package lil_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_T_MIN        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_USED = 2'd2;

    localparam int CFG_DATA_W  = 32;
    localparam int ENTRIES_W   = 11;
    localparam int ENTRY_IDX_W = 10;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef struct packed {
        logic                          func;
        logic [ENTRY_IDX_W-1:0]        entry_index;
        logic signed [31:0]            entry_value;
        logic signed [31:0]            coordinate;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0]            value;
        logic                          clamped_low;
        logic                          clamped_high;
    } t_out_item;

endpackage

`default_nettype wire

### sv/linear_interp_lut.sv
// ============================================================================
// linear_interp_lut: uniformly spaced 1-D lookup table with interpolation
// Load items write table entries; lookup items map a coordinate to a
// Q(FRACTION_BITS) position, clamp it to the table and interpolate linearly.
// ============================================================================
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------
//  input    | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
//  output   | o_out_valid / i_out_ready | o_out_data (t_out_item)
//  config   | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
//  One item enters per cycle while the output is not stalled. A lookup
//  result passes, once accepted, through difference, position multiply,
//  table read, delta, fraction multiply and final add into the output
//  register. Loads write the table in the read stage and leave no result.
//  Each stage holds while the next one is full and stalled, so bubbles
//  close up; no clearing pass, the table is undefined until written.
//  Synchronous active-low reset clears valid bits, sets config defaults.
// ============================================================================
`default_nettype none

module linear_interp_lut #(
    parameter int TABLE_DEPTH   = 1024,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [lil_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [lil_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire lil_pkg::t_in_item                 i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output lil_pkg::t_out_item                     o_out_data
);

    localparam int AW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FB = FRACTION_BITS;
    localparam int PW = FB + 34;

    // configuration
    logic signed [31:0]                 r_t_min;
    logic [31:0]                        r_scale;
    logic [lil_pkg::ENTRIES_W-1:0]      r_entries;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_min   <= '0;
            r_scale   <= 32'd65536;
            r_entries <= lil_pkg::ENTRIES_W'(2);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lil_pkg::CFG_T_MIN:        r_t_min   <= i_cfg_data;
                lil_pkg::CFG_SCALE:        r_scale   <= i_cfg_data;
                lil_pkg::CFG_ENTRIES_USED: r_entries <= i_cfg_data[lil_pkg::ENTRIES_W-1:0];
                default: ;
            endcase
        end
    end

    // last entry in use, with the entry count held to [2, TABLE_DEPTH]
    logic [31:0]   used_cnt;
    logic [AW-1:0] last_idx;

    always_comb begin
        if (r_entries < lil_pkg::ENTRIES_W'(2)) begin
            used_cnt = 32'd2;
        end else if (32'(r_entries) > 32'(TABLE_DEPTH)) begin
            used_cnt = 32'(TABLE_DEPTH);
        end else begin
            used_cnt = 32'(r_entries);
        end
        last_idx = AW'(used_cnt - 32'd1);
    end

    // stage enables: a stage loads when it is empty or its item moves on
    logic en_a, en_b, en_c, en_d, en_e, en_o;

    // stage A: coordinate difference
    logic                               r_a_vld;
    logic                               r_a_func;
    logic [lil_pkg::ENTRY_IDX_W-1:0]    r_a_eidx;
    logic signed [31:0]                 r_a_eval;
    logic signed [32:0]                 r_a_diff;

    // stage B: position product
    logic                               r_b_vld;
    logic                               r_b_func;
    logic [lil_pkg::ENTRY_IDX_W-1:0]    r_b_eidx;
    logic signed [31:0]                 r_b_eval;
    logic signed [65:0]                 r_b_pos;

    // stage C: table read data
    logic                               r_c_vld;
    logic [FB-1:0]                      r_c_frac;
    logic                               r_c_low;
    logic                               r_c_high;
    logic signed [31:0]                 c_lo;
    logic signed [31:0]                 c_hi;

    // stage D: neighbor delta
    logic                               r_d_vld;
    logic [FB-1:0]                      r_d_frac;
    logic                               r_d_low;
    logic                               r_d_high;
    logic signed [31:0]                 r_d_lo;
    logic signed [32:0]                 r_d_delta;

    // stage E: fraction product
    logic                               r_e_vld;
    logic                               r_e_low;
    logic                               r_e_high;
    logic signed [31:0]                 r_e_lo;
    logic signed [PW-1:0]               r_e_prod;

    // output register
    logic                               r_o_vld;
    lil_pkg::t_out_item                 r_o_data;

    assign en_o = !r_o_vld || i_out_ready;
    assign en_e = !r_e_vld || en_o;
    assign en_d = !r_d_vld || en_e;
    assign en_c = !r_c_vld || en_d;
    assign en_b = !r_b_vld || en_c;
    assign en_a = !r_a_vld || en_b;

    assign o_in_ready  = en_a;
    assign o_out_valid = r_o_vld;
    assign o_out_data  = r_o_data;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (en_a) r_a_vld <= i_in_valid;
            if (en_b) r_b_vld <= r_a_vld;
            // loads end at the table write
            if (en_c) r_c_vld <= r_b_vld && (r_b_func == lil_pkg::FUNC_LOOKUP);
            if (en_d) r_d_vld <= r_c_vld;
            if (en_e) r_e_vld <= r_d_vld;
            if (en_o) r_o_vld <= r_e_vld;
        end
    end

    // stage A
    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_func <= i_in_data.func;
            r_a_eidx <= i_in_data.entry_index;
            r_a_eval <= i_in_data.entry_value;
            r_a_diff <= 33'(i_in_data.coordinate) - 33'(r_t_min);
        end
    end

    // stage B
    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_func <= r_a_func;
            r_b_eidx <= r_a_eidx;
            r_b_eval <= r_a_eval;
            r_b_pos  <= r_a_diff * $signed({1'b0, r_scale});
        end
    end

    // position split and clamp
    logic          pos_low;
    logic          pos_high;
    logic [AW-1:0] pos_idx;
    logic [AW-1:0] rd_addr0;
    logic [AW-1:0] rd_addr1;
    logic          tbl_we;

    always_comb begin
        pos_idx  = r_b_pos[FB+AW-1:FB];
        pos_low  = r_b_pos[65];
        pos_high = !pos_low && ((|r_b_pos[64:FB+AW]) || (pos_idx >= last_idx));
        if (pos_low) begin
            rd_addr0 = '0;
        end else if (pos_high) begin
            rd_addr0 = last_idx;
        end else begin
            rd_addr0 = pos_idx;
        end
        rd_addr1 = pos_idx + AW'(1);
        tbl_we   = r_b_vld && (r_b_func == lil_pkg::FUNC_LOAD) && en_c
                   && (32'(r_b_eidx) < 32'(TABLE_DEPTH));
    end

    lil_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (tbl_we),
        .i_waddr  (AW'(r_b_eidx)),
        .i_wdata  (r_b_eval),
        .i_re     (en_c),
        .i_raddr0 (rd_addr0),
        .i_raddr1 (rd_addr1),
        .o_rdata0 (c_lo),
        .o_rdata1 (c_hi)
    );

    // stage C
    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_c_low  <= pos_low;
            r_c_high <= pos_high;
            r_c_frac <= (pos_low || pos_high) ? '0 : r_b_pos[FB-1:0];
        end
    end

    // stage D: zero the delta on a clamp so the far neighbor never matters
    always_ff @(posedge i_clk) begin
        if (en_d) begin
            r_d_frac  <= r_c_frac;
            r_d_low   <= r_c_low;
            r_d_high  <= r_c_high;
            r_d_lo    <= c_lo;
            r_d_delta <= (r_c_low || r_c_high) ? '0 : (33'(c_hi) - 33'(c_lo));
        end
    end

    // stage E
    always_ff @(posedge i_clk) begin
        if (en_e) begin
            r_e_low  <= r_d_low;
            r_e_high <= r_d_high;
            r_e_lo   <= r_d_lo;
            r_e_prod <= $signed({1'b0, r_d_frac}) * r_d_delta;
        end
    end

    // output: lo plus the low word of the floor-shifted product
    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_o_data.value        <= r_e_lo + r_e_prod[FB+31:FB];
            r_o_data.clamped_low  <= r_e_low;
            r_o_data.clamped_high <= r_e_high;
        end
    end

endmodule

`default_nettype wire

### sv/lil_ram.sv
// ============================================================================
// lil_ram: table storage, one write port and two registered read ports
// Read data updates only when the read enable is high, so a stalled
// pipeline stage keeps its data.
// ============================================================================
`default_nettype none

module lil_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [AW-1:0]        i_waddr,
    input  wire logic signed [31:0]   i_wdata,
    input  wire logic                 i_re,
    input  wire logic [AW-1:0]        i_raddr0,
    input  wire logic [AW-1:0]        i_raddr1,
    output logic signed [31:0]        o_rdata0,
    output logic signed [31:0]        o_rdata1
);

    logic signed [31:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata0 <= r_mem[i_raddr0];
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule

`default_nettype wire
